// ===== rtl/qts_pkg.sv =====
// Shared types, character codes and helper functions for the quoted token splitter.
package qts_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int RUN_MAX         = 3;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;

    // All results caused by one input word
    typedef struct packed {
        logic [1:0]                  cnt;
        logic [RUN_MAX-1:0][1:0]     kind;
        logic [RUN_MAX-1:0][7:0]     chr;
    } run_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c inside {CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE};
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c);
        logic [7:0] t;
        case (c)
            CH_LOWER_N: t = CH_LF;
            CH_LOWER_T: t = CH_TAB;
            CH_LOWER_R: t = CH_CR;
            default:    t = c;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/qts_if.sv =====
// Valid/ready channel interfaces for text input and token output.
interface qts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface qts_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output kind, output out_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input out_char, input last_of_run,
                    output ready);
endinterface

// ===== rtl/qts_front.sv =====
// Front end: accepts text words, tracks lexer state and builds the result run per word.
module qts_front (
    input  logic          clk,
    input  logic          rst_n,
    qts_in_if.sink        text_in,
    input  logic          q_full,
    output logic          push,
    output qts_pkg::run_t push_run
);
    import qts_pkg::*;

    logic ins_reg, esc_reg, tok_reg, start_reg, skip_reg;
    logic ins_next, esc_next, tok_next, start_next, skip_next;
    logic acc;
    logic [7:0] c;
    logic [1:0] n;
    logic skip;
    run_t run;

    assign text_in.ready = !q_full;
    assign acc = text_in.valid && text_in.ready;
    assign c = text_in.text_byte;

    always_comb
    begin
        run = '0;
        n = '0;
        ins_next = ins_reg;
        esc_next = esc_reg;
        tok_next = tok_reg;
        skip = skip_reg || (start_reg && c == CH_HASH);
        if (!skip)
        begin
            if (c == CH_QUOTE && !esc_reg)
            begin
                ins_next = !ins_reg;
                run.kind[n] = KIND_CHAR;
                run.chr[n] = c;
                n = n + 2'd1;
                tok_next = 1'b1;
                if (!ins_next)
                begin
                    run.kind[n] = KIND_END;
                    n = n + 2'd1;
                    tok_next = 1'b0;
                end
            end
            else if (c == CH_BACKSLASH && !esc_reg)
            begin
                esc_next = 1'b1;
            end
            else if (esc_reg)
            begin
                run.kind[n] = KIND_CHAR;
                run.chr[n] = esc_char(c);
                n = n + 2'd1;
                tok_next = 1'b1;
                esc_next = 1'b0;
            end
            else if (ins_reg)
            begin
                run.kind[n] = KIND_CHAR;
                run.chr[n] = c;
                n = n + 2'd1;
                tok_next = 1'b1;
            end
            else if (is_space(c))
            begin
                if (tok_reg)
                begin
                    run.kind[n] = KIND_END;
                    n = n + 2'd1;
                end
                tok_next = 1'b0;
            end
            else if (is_bracket(c))
            begin
                if (tok_reg)
                begin
                    run.kind[n] = KIND_END;
                    n = n + 2'd1;
                end
                run.kind[n] = KIND_CHAR;
                run.chr[n] = c;
                n = n + 2'd1;
                run.kind[n] = KIND_END;
                n = n + 2'd1;
                tok_next = 1'b0;
            end
            else
            begin
                run.kind[n] = KIND_CHAR;
                run.chr[n] = c;
                n = n + 2'd1;
                tok_next = 1'b1;
            end
            if (text_in.line_end)
            begin
                if (tok_next)
                begin
                    run.kind[n] = KIND_END;
                    n = n + 2'd1;
                end
                if (ins_next)
                begin
                    run.kind[n] = KIND_ERR;
                    n = n + 2'd1;
                end
            end
        end
        run.cnt = n;
        start_next = 1'b0;
        skip_next = skip;
        if (text_in.line_end)
        begin
            ins_next = 1'b0;
            esc_next = 1'b0;
            tok_next = 1'b0;
            start_next = 1'b1;
            skip_next = 1'b0;
        end
    end

    assign push = acc && (run.cnt != 2'd0);
    assign push_run = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            tok_reg   <= 1'b0;
            start_reg <= 1'b1;
            skip_reg  <= 1'b0;
        end
        else if (acc)
        begin
            ins_reg   <= ins_next;
            esc_reg   <= esc_next;
            tok_reg   <= tok_next;
            start_reg <= start_next;
            skip_reg  <= skip_next;
        end
    end

    // comment lines produce nothing
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        acc && skip_reg |-> !push)
        else $error("result pushed while skipping a comment line");

    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        acc && text_in.line_end |=> start_reg && !ins_reg && !esc_reg && !tok_reg && !skip_reg)
        else $error("state not restored after line end");

endmodule

// ===== rtl/qts_queue.sv =====
// Small FIFO of result runs between front and back end.
module qts_queue #(
    parameter int DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qts_pkg::run_t push_run,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output qts_pkg::run_t head_run
);
    import qts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || do_pop)
        else $error("run queue overflow");

endmodule

// ===== rtl/qts_back.sv =====
// Back end: walks each queued run and presents its results one per cycle while the receiver is ready.
module qts_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  qts_pkg::run_t head_run,
    output logic          pop,
    qts_out_if.source     token_out
);
    import qts_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!out_valid_reg || token_out.ready);
    assign is_last = (idx_reg == head_run.cnt - 2'd1);
    assign pop     = load && is_last;

    assign token_out.valid       = out_valid_reg;
    assign token_out.kind        = kind_reg;
    assign token_out.out_char    = char_reg;
    assign token_out.last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (token_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head_run.kind[idx_reg];
            char_reg <= head_run.chr[idx_reg];
            last_reg <= is_last;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head_run.cnt)
        else $error("run index beyond run length");

endmodule

// ===== rtl/quoted_token_splitter_core.sv =====
// Top level of the quoted token splitter: front end, run queue and back end.
// Splits text into token characters, end-of-token marks and open-string errors. One text word is
// accepted per cycle while the run queue has room; each word yields zero to
// three results, and results leave at one per cycle from a registered output
// while the receiver is ready. A word's run is written into the run queue and
// then loaded result by result into the output register, so a long run holds
// the back end while it drains; the queue of QUEUE_DEPTH runs absorbs such
// bursts, and input stalls only when it fills.
module quoted_token_splitter_core #(
    parameter int QUEUE_DEPTH = qts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qts_in_if.sink     text_in,
    qts_out_if.source  token_out
);
    import qts_pkg::*;

    logic q_full;
    logic push;
    run_t push_run;
    logic pop;
    logic head_valid;
    run_t head_run;

    qts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .q_full   (q_full),
        .push     (push),
        .push_run (push_run)
    );

    qts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    qts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_run   (head_run),
        .pop        (pop),
        .token_out  (token_out)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for quoted_token_splitter_core: directed and random lines checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import qts_pkg::*;

    localparam int RANDOM_WORDS  = 220;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int MAX_REPORTS   = 10;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } token_res_t;

    logic clk = 1'b0;
    logic rst_n;

    qts_in_if  text_if ();
    qts_out_if tok_if ();

    quoted_token_splitter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (tok_if)
    );

    always #2 clk = ~clk;

    // tokenizer state tracked alongside the block
    logic str_open;
    logic esc_pending;
    logic tok_open;
    logic line_start;
    logic in_comment;

    token_res_t expected_q [$];
    token_res_t run_buf [RUN_MAX];
    int         run_n;
    logic [7:0] line_buf [$];

    int words_sent;
    int lines_sent;
    int comment_lines;
    int results_checked;
    int mismatch_cnt;
    int cycle_cnt;
    int burst_left;
    int stall_mode;
    int stall_left;

    task automatic clear_line_state();
        str_open    = 1'b0;
        esc_pending = 1'b0;
        tok_open    = 1'b0;
        line_start  = 1'b1;
        in_comment  = 1'b0;
    endtask

    task automatic append_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic add_result(input logic [1:0] kind, input logic [7:0] ch);
        run_buf[run_n].kind = kind;
        run_buf[run_n].ch   = ch;
        run_buf[run_n].last = 1'b0;
        run_n++;
    endtask

    task automatic emit_char(input logic [7:0] ch);
        add_result(KIND_CHAR, ch);
        tok_open = 1'b1;
    endtask

    task automatic close_token();
        if (tok_open)
        begin
            add_result(KIND_END, 8'h00);
            tok_open = 1'b0;
        end
    endtask

    task automatic predict_tokens(input logic [7:0] c, input logic le);
        logic [7:0] t;
        run_n = 0;
        if (line_start && c == CH_HASH)
            in_comment = 1'b1;
        line_start = 1'b0;
        if (!in_comment)
        begin
            if (c == CH_QUOTE && !esc_pending)
            begin
                str_open = !str_open;
                emit_char(c);
                if (!str_open)
                    close_token();
            end
            else if (c == CH_BACKSLASH && !esc_pending)
                esc_pending = 1'b1;
            else if (esc_pending)
            begin
                case (c)
                    CH_LOWER_N: t = CH_LF;
                    CH_LOWER_T: t = CH_TAB;
                    CH_LOWER_R: t = CH_CR;
                    default:    t = c;
                endcase
                emit_char(t);
                esc_pending = 1'b0;
            end
            else if (str_open)
                emit_char(c);
            else
            begin
                case (c)
                    CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR:
                        close_token();
                    CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE:
                    begin
                        close_token();
                        emit_char(c);
                        close_token();
                    end
                    default:
                        emit_char(c);
                endcase
            end
            if (le)
            begin
                close_token();
                if (str_open)
                    add_result(KIND_ERR, 8'h00);
            end
        end
        if (le)
            clear_line_state();
        for (int i = 0; i < run_n; i++)
        begin
            t = 8'h00;
            if (i == run_n - 1)
                run_buf[i].last = 1'b1;
            expected_q = {expected_q, run_buf[i]};
        end
    endtask

    // one word per handshake; gaps only between bursts
    task automatic send_word(input logic [7:0] c, input logic le);
        int gap;
        text_if.valid     <= 1'b1;
        text_if.text_byte <= c;
        text_if.line_end  <= le;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        predict_tokens(c, le);
        words_sent++;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 40);
            else
                burst_left = $urandom_range(1, 12);
        end
        else
            burst_left--;
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line();
        if (line_buf[0] == CH_HASH)
            comment_lines++;
        for (int i = 0; i < line_buf.size(); i++)
            send_word(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
        line_buf.delete();
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_bracket();
        case ($urandom_range(0, 5))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACK;
            3:       return CH_RBRACK;
            4:       return CH_LBRACE;
            default: return CH_RBRACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 15))
            0:       return CH_HASH;
            1, 2:    return CH_ZERO + 8'($urandom_range(0, 9));
            default: return CH_LOWER_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_escaped();
        case ($urandom_range(0, 5))
            0:       return CH_LOWER_N;
            1:       return CH_LOWER_T;
            2:       return CH_LOWER_R;
            3:       return CH_QUOTE;
            4:       return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_word();
        int k;
        k = $urandom_range(1, 4);
        repeat (k) append_byte(pick_word_char());
    endtask

    task automatic push_string_body();
        int k;
        append_byte(CH_QUOTE);
        k = $urandom_range(0, 5);
        repeat (k)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    append_byte(CH_BACKSLASH);
                    append_byte(pick_escaped());
                end
                1:       append_byte(pick_blank());
                2:       append_byte(pick_bracket());
                default: append_byte(pick_word_char());
            endcase
        end
    endtask

    task automatic build_random_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 || $urandom_range(0, 3) == 0)
                begin
                    append_byte(pick_blank());
                    if ($urandom_range(0, 2) == 0)
                        append_byte(pick_blank());
                end
                case ($urandom_range(0, 5))
                    0, 1: push_word();
                    2:
                    begin
                        push_string_body();
                        append_byte(CH_QUOTE);
                    end
                    3:    append_byte(pick_bracket());
                    4:
                    begin
                        append_byte(CH_BACKSLASH);
                        append_byte(pick_escaped());
                    end
                    default:
                    begin
                        push_word();
                        append_byte(pick_bracket());
                        push_word();
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                append_byte(pick_blank());
        end
        else if (r < 75)
        begin
            append_byte(CH_HASH);
            n = $urandom_range(0, 5);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 90)
        begin
            n = $urandom_range(1, 8);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            // unclosed string or dangling backslash
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_word();
                push_string_body();
            end
            else
            begin
                push_word();
                append_byte(CH_BACKSLASH);
            end
        end
    endtask

    task automatic test_brackets_and_extremes();
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(CH_TAB);
        queue_text("()[]{}");
        send_line();
    endtask

    task automatic test_strings_and_escapes();
        // escaped quote in string, \n, closing quote, trailing backslash
        queue_text("\"\\\"\\n\"a\\");
        send_line();
        // escaped backslash, \r, string left open at line end
        queue_text("\\\\\\r\"");
        send_line();
        // \t, hash mid-line, vertical tab at line end
        queue_text("\\t#");
        append_byte(CH_VT);
        send_line();
    endtask

    task automatic test_comment_line();
        queue_text("#\"");
        send_line();
    endtask

    task automatic test_random_lines();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            build_random_line();
            send_line();
        end
    endtask

    task automatic flag_mismatch(input string what, input token_res_t want, input token_res_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch (%s) cycle %0d: exp %0d/%02h/%0b got %0d/%02h/%0b",
                     what, cycle_cnt, want.kind, want.ch, want.last,
                     got.kind, got.ch, got.last);
    endtask

    always @(posedge clk)
    begin : result_check
        token_res_t want;
        token_res_t got;
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            got.kind = tok_if.kind;
            got.ch   = tok_if.out_char;
            got.last = tok_if.last_of_run;
            if (expected_q.size() == 0)
            begin
                want = '0;
                flag_mismatch("unexpected", want, got);
            end
            else
            begin
                want = expected_q.pop_front();
                results_checked++;
                if (got.kind !== want.kind || got.ch !== want.ch || got.last !== want.last)
                    flag_mismatch("field", want, got);
            end
        end
    end

    // receiver: switches between always ready, coin flip, mostly stalled and alternating
    initial
    begin
        tok_if.ready = 1'b0;
        stall_mode   = 0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 40);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       tok_if.ready <= 1'b1;
                1:       tok_if.ready <= 1'($urandom_range(0, 1));
                2:       tok_if.ready <= ($urandom_range(0, 3) == 0);
                default: tok_if.ready <= stall_left[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = 8'h00;
        text_if.line_end  = 1'b0;
        words_sent        = 0;
        lines_sent        = 0;
        comment_lines     = 0;
        results_checked   = 0;
        mismatch_cnt      = 0;
        cycle_cnt         = 0;
        burst_left        = 0;
        clear_line_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_brackets_and_extremes();
        test_strings_and_escapes();
        test_comment_line();
        test_random_lines();

        text_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words in %0d lines (%0d comment lines), checked %0d results",
                 words_sent, lines_sent, comment_lines, results_checked);
        $display("mismatches: %0d", mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
